// ===== hdl/hbmt_pkg.sv =====
// Shared types and codes for the heartbeat membership table.
package hbmt_pkg;

  localparam logic [1:0] FUNC_BEAT  = 2'd0;
  localparam logic [1:0] FUNC_JOIN  = 2'd1;
  localparam logic [1:0] FUNC_ENTRY = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_SEND  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REMOVED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [2:0] CFG_OWN_ID    = 3'd0;
  localparam logic [2:0] CFG_OWN_PORT  = 3'd1;
  localparam logic [2:0] CFG_PERIOD    = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd3;
  localparam logic [2:0] CFG_INTRO     = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] member_id;
    logic [15:0] member_port;
    logic [31:0] member_heartbeat;
    logic signed [31:0] member_timestamp;
  } hbmt_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest_id;
    logic [15:0] dest_port;
    logic [31:0] entry_id;
    logic [15:0] entry_port;
    logic [31:0] entry_heartbeat;
    logic signed [31:0] entry_timestamp;
    logic [5:0]  member_count;
    logic [1:0]  status;
    logic        last;
  } hbmt_out_t;

endpackage

// ===== hdl/hbmt_front.sv =====
// Front end: accepts commands into a two-entry queue.
module hbmt_front
  import hbmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hbmt_in_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output hbmt_in_t head
);
  hbmt_in_t q_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_data;
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hdl/hbmt_back.sv =====
// Back end: table memory and the sequencer that serves each command.
module hbmt_back
  import hbmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  hbmt_in_t   cmd,
  output logic       cmd_pop,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [31:0] cfg_data,
  output logic       out_strobe,
  output hbmt_out_t  out_data
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_DUMP  = 7'b0000100,
    S_SEND  = 7'b0001000,
    S_STALE = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  logic [31:0] mem_id [TABLE_DEPTH];
  logic [15:0] mem_port [TABLE_DEPTH];
  logic [31:0] mem_beat [TABLE_DEPTH];
  logic [31:0] mem_stamp [TABLE_DEPTH];

  state_t state_r, state_nxt;
  hbmt_in_t cmd_r;
  logic [CW-1:0] count_r, idx_r;
  logic [31:0] own_id_r, own_beat_r, time_r;
  logic [15:0] own_port_r;
  logic [7:0]  period_r, cd_r;
  logic [9:0]  timeout_r;
  logic        joined_r;
  logic [1:0]  status_r;
  logic [31:0] rid_r;
  logic [15:0] rport_r;
  logic        rd_ok_r;
  logic        send_r;
  logic [CW-1:0] rm_r;
  logic [31:0] q_id, q_beat, q_stamp;
  logic [15:0] q_port;

  // Registered read port; rd_ok_r flags that q_* reflects entry idx_r.
  logic [IW-1:0] ra;
  logic [IW-1:0] ix;
  assign ix = idx_r[IW-1:0];
  assign ra = ix;

  logic in_range, match, is_self, stale, last_entry;
  logic signed [33:0] diff;
  assign in_range = idx_r < count_r;
  assign last_entry = idx_r + CW'(1) >= count_r;
  assign match = q_id == cmd_r.member_id && q_port == cmd_r.member_port;
  assign is_self = q_id == own_id_r && q_port == own_port_r;
  assign diff = 34'(signed'(time_r)) - 34'(signed'(q_stamp));
  assign stale = diff > signed'({24'd0, timeout_r});

  logic [31:0] stamp_new;
  assign stamp_new = cmd_r.func == FUNC_ENTRY ? cmd_r.member_timestamp : time_r;

  // write port
  logic we;
  logic [IW-1:0] wa;
  logic [31:0] w_id, w_beat, w_stamp;
  logic [15:0] w_port;

  always_ff @(posedge clk) begin
    q_id <= mem_id[ra]; q_port <= mem_port[ra];
    q_beat <= mem_beat[ra]; q_stamp <= mem_stamp[ra];
    if (we) begin
      mem_id[wa] <= w_id; mem_port[wa] <= w_port;
      mem_beat[wa] <= w_beat; mem_stamp[wa] <= w_stamp;
    end
  end

  hbmt_out_t o_nxt;
  logic o_stb_nxt;
  logic [CW-1:0] idx_nxt, count_nxt, rm_nxt;
  logic [1:0] status_nxt;
  logic [31:0] rid_nxt, own_beat_nxt, time_nxt;
  logic [15:0] rport_nxt;
  logic [7:0] cd_nxt;
  logic joined_nxt, rd_ok_nxt, send_nxt;

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; count_nxt = count_r;
    status_nxt = status_r; rid_nxt = rid_r; rport_nxt = rport_r;
    own_beat_nxt = own_beat_r; time_nxt = time_r; cd_nxt = cd_r;
    joined_nxt = joined_r; rd_ok_nxt = 1'b0;
    send_nxt = send_r; rm_nxt = rm_r;
    we = 1'b0; wa = ix;
    w_id = cmd_r.member_id; w_port = cmd_r.member_port;
    w_beat = cmd_r.member_heartbeat; w_stamp = stamp_new;
    cmd_pop = 1'b0; o_stb_nxt = 1'b0; o_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1; idx_nxt = '0; status_nxt = ST_OK;
          rid_nxt = '0; rport_nxt = '0;
          if (cmd.func == FUNC_TICK) begin
            if (!joined_r) begin
              status_nxt = ST_IGNORED; state_nxt = S_DONE;
            end else if (cd_r == 8'd0) begin
              own_beat_nxt = own_beat_r + 32'd1; cd_nxt = period_r;
              send_nxt = 1'b1; state_nxt = S_STALE;
            end else begin
              cd_nxt = cd_r - 8'd1; send_nxt = 1'b0; state_nxt = S_STALE;
            end
          end else begin
            if (cmd.func == FUNC_ENTRY) joined_nxt = 1'b1;
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (!in_range) begin
          if (count_r >= CW'(TABLE_DEPTH)) status_nxt = ST_FULL;
          else begin
            we = 1'b1; count_nxt = count_r + CW'(1);
          end
          idx_nxt = '0;
          state_nxt = cmd_r.func == FUNC_JOIN ? S_DUMP : S_DONE;
        end else if (!rd_ok_r) rd_ok_nxt = 1'b1;
        else if (match) begin
          if (cmd_r.member_heartbeat > q_beat) begin
            we = 1'b1; w_id = q_id; w_port = q_port;
          end
          idx_nxt = '0;
          state_nxt = cmd_r.func == FUNC_JOIN ? S_DUMP : S_DONE;
        end else idx_nxt = idx_r + CW'(1);
      end
      S_DUMP: begin
        if (!in_range) state_nxt = S_DONE;
        else if (!rd_ok_r) rd_ok_nxt = 1'b1;
        else begin
          o_stb_nxt = 1'b1;
          o_nxt.kind = KIND_REPLY; o_nxt.dest_id = cmd_r.member_id;
          o_nxt.dest_port = cmd_r.member_port; o_nxt.entry_id = q_id;
          o_nxt.entry_port = q_port; o_nxt.entry_heartbeat = q_beat;
          o_nxt.entry_timestamp = q_stamp; o_nxt.member_count = 6'(count_r);
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_STALE: begin
        // find the first stale member first, so sends can carry the final count
        if (!in_range) begin
          time_nxt = time_r + 32'd1; idx_nxt = '0;
          state_nxt = send_r ? S_SEND : S_DONE;
        end else if (!rd_ok_r) rd_ok_nxt = 1'b1;
        else if (!is_self && stale) begin
          rid_nxt = q_id; rport_nxt = q_port; status_nxt = ST_REMOVED;
          rm_nxt = idx_r; time_nxt = time_r + 32'd1;
          if (send_r) begin
            idx_nxt = '0; state_nxt = S_SEND;
          end else begin
            idx_nxt = idx_r + CW'(1); state_nxt = S_SHIFT;
          end
        end else idx_nxt = idx_r + CW'(1);
      end
      S_SEND: begin
        if (!in_range) begin
          if (status_r == ST_REMOVED) begin
            idx_nxt = rm_r + CW'(1); state_nxt = S_SHIFT;
          end else state_nxt = S_DONE;
        end else if (!rd_ok_r) rd_ok_nxt = 1'b1;
        else begin
          if (!is_self) begin
            o_stb_nxt = 1'b1;
            o_nxt.kind = KIND_SEND; o_nxt.dest_id = q_id; o_nxt.dest_port = q_port;
            o_nxt.entry_id = own_id_r; o_nxt.entry_port = own_port_r;
            o_nxt.entry_heartbeat = own_beat_r;
            o_nxt.member_count = 6'(count_r - CW'(status_r == ST_REMOVED));
          end
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SHIFT: begin
        // copy entry idx down to idx-1, one entry at a time, each after its registered read
        if (!in_range) begin
          count_nxt = count_r - CW'(1); state_nxt = S_DONE;
        end else if (!rd_ok_r) rd_ok_nxt = 1'b1;
        else begin
          we = 1'b1; wa = IW'(idx_r - CW'(1));
          w_id = q_id; w_port = q_port; w_beat = q_beat; w_stamp = q_stamp;
          if (last_entry) begin
            count_nxt = count_r - CW'(1); state_nxt = S_DONE;
          end else idx_nxt = idx_r + CW'(1);
        end
      end
      S_DONE: begin
        o_stb_nxt = 1'b1;
        o_nxt.kind = KIND_DONE; o_nxt.entry_id = rid_r; o_nxt.entry_port = rport_r;
        o_nxt.member_count = 6'(count_r); o_nxt.status = status_r; o_nxt.last = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_idx == CFG_PERIOD) cd_nxt = cfg_data[7:0];
    if (cfg_we && cfg_idx == CFG_INTRO) joined_nxt = cfg_data[0];
  end

  always_ff @(posedge clk) begin
    out_data <= o_nxt;
    if (cmd_pop) cmd_r <= cmd;
    idx_r <= idx_nxt; status_r <= status_nxt; rid_r <= rid_nxt; rport_r <= rport_nxt;
    send_r <= send_nxt; rm_r <= rm_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE; out_strobe <= 1'b0; rd_ok_r <= 1'b0;
      count_r <= '0; time_r <= '1; cd_r <= 8'd5; own_beat_r <= '0;
      joined_r <= 1'b0; own_id_r <= '0; own_port_r <= '0; period_r <= 8'd5;
      timeout_r <= 10'd20;
    end else begin
      state_r <= state_nxt; out_strobe <= o_stb_nxt; rd_ok_r <= rd_ok_nxt;
      count_r <= count_nxt; time_r <= time_nxt; cd_r <= cd_nxt;
      own_beat_r <= own_beat_nxt; joined_r <= joined_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_OWN_ID:   own_id_r <= cfg_data;
          CFG_OWN_PORT: own_port_r <= cfg_data[15:0];
          CFG_PERIOD:   period_r <= cfg_data[7:0];
          CFG_TIMEOUT:  timeout_r <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== hdl/heartbeat_membership_table_unit.sv =====
// Top level of the heartbeat membership table.
//  channel  | ports                          | handshake
//  input    | start, busy, in_item           | taken when start && !busy
//  result   | out_strobe, out_item           | one cycle, no back-pressure
//  config   | cfg_we, cfg_index, cfg_data    | write on cfg_we
// An item visits the table entry by entry in each pass (search or dump; on a tick,
// a stale pass, then a send pass when one is due), and after a removal moves each
// later entry down; every entry visited waits on the single registered table read
// port. Reset is synchronous and leaves the table empty; busy is high while the
// two-entry queue is full. The receiver cannot stall, so no result waits.
module heartbeat_membership_table_unit
  import hbmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  hbmt_in_t   in_item,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic       out_strobe,
  output hbmt_out_t  out_item
);
  logic pop, ne;
  hbmt_in_t head;

  hbmt_front u_front (
    .clk, .rst_n, .push(start && !busy), .push_data(in_item), .pop,
    .full(busy), .not_empty(ne), .head
  );

  hbmt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid(ne), .cmd(head), .cmd_pop(pop),
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .out_strobe, .out_data(out_item)
  );

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.member_count <= 6'(TABLE_DEPTH)) else $error("count");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> ne) else $error("pop empty");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |-> out_item.kind == KIND_DONE) else $error("last");
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the heartbeat membership table unit.
module tb_top;
  import hbmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 32;
  localparam int IDLE_LIMIT = 5000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  hbmt_in_t   in_item = '0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic       out_strobe;
  hbmt_out_t  out_item;

  heartbeat_membership_table_unit #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  always #10 clk = ~clk;

  // predictor copy of registers and table
  logic [31:0] m_own_id = '0;
  logic [15:0] m_own_port = '0;
  logic [7:0]  m_period = 8'd5;
  logic [9:0]  m_timeout = 10'd20;
  logic [31:0] m_id [DEPTH];
  logic [15:0] m_port [DEPTH];
  logic [31:0] m_beat [DEPTH];
  logic [31:0] m_stamp [DEPTH];
  int          m_count = 0;
  logic [31:0] m_time = 32'hFFFF_FFFF;
  logic [7:0]  m_countdown = 8'd5;
  logic [31:0] m_own_beat = '0;
  logic        m_joined = 1'b0;

  hbmt_out_t expected_results[$];
  int        mismatches = 0;
  bit        failed = 1'b0;

  // sender burst shaping
  int burst_left = 0;
  bit no_gaps = 1'b0;

  function automatic logic [1:0] merge_member(logic [31:0] id, logic [15:0] port,
                                              logic [31:0] beat, logic [31:0] stamp);
    for (int i = 0; i < m_count; i++) begin
      if (m_id[i] == id && m_port[i] == port) begin
        if (beat > m_beat[i]) begin
          m_beat[i] = beat;
          m_stamp[i] = stamp;
        end
        return ST_OK;
      end
    end
    if (m_count >= DEPTH) return ST_FULL;
    m_id[m_count] = id;
    m_port[m_count] = port;
    m_beat[m_count] = beat;
    m_stamp[m_count] = stamp;
    m_count++;
    return ST_OK;
  endfunction

  function automatic bit is_own(int i);
    return m_id[i] == m_own_id && m_port[i] == m_own_port;
  endfunction

  task automatic predict_membership(hbmt_in_t it);
    hbmt_out_t r;
    hbmt_out_t step_q[$];
    logic [1:0] st;
    logic [31:0] rid;
    logic [15:0] rport;
    longint diff;
    st = ST_OK;
    rid = '0;
    rport = '0;
    case (it.func)
      FUNC_BEAT: st = merge_member(it.member_id, it.member_port, it.member_heartbeat, m_time);
      FUNC_JOIN: begin
        st = merge_member(it.member_id, it.member_port, it.member_heartbeat, m_time);
        for (int i = 0; i < m_count; i++) begin
          r = '0;
          r.kind = KIND_REPLY;
          r.dest_id = it.member_id;
          r.dest_port = it.member_port;
          r.entry_id = m_id[i];
          r.entry_port = m_port[i];
          r.entry_heartbeat = m_beat[i];
          r.entry_timestamp = m_stamp[i];
          step_q.insert(step_q.size(), r);
        end
      end
      FUNC_ENTRY: begin
        m_joined = 1'b1;
        st = merge_member(it.member_id, it.member_port, it.member_heartbeat,
                          it.member_timestamp);
      end
      default: begin
        if (!m_joined) st = ST_IGNORED;
        else begin
          if (m_countdown == 0) begin
            m_own_beat++;
            for (int i = 0; i < m_count; i++) begin
              if (!is_own(i)) begin
                r = '0;
                r.kind = KIND_SEND;
                r.dest_id = m_id[i];
                r.dest_port = m_port[i];
                r.entry_id = m_own_id;
                r.entry_port = m_own_port;
                r.entry_heartbeat = m_own_beat;
                step_q.insert(step_q.size(), r);
              end
            end
            m_countdown = m_period;
          end else m_countdown--;
          for (int i = 0; i < m_count; i++) begin
            diff = longint'($signed(m_time)) - longint'($signed(m_stamp[i]));
            if (!is_own(i) && diff > longint'(m_timeout)) begin
              rid = m_id[i];
              rport = m_port[i];
              for (int j = i; j + 1 < m_count; j++) begin
                m_id[j] = m_id[j+1];
                m_port[j] = m_port[j+1];
                m_beat[j] = m_beat[j+1];
                m_stamp[j] = m_stamp[j+1];
              end
              m_count--;
              st = ST_REMOVED;
              break;
            end
          end
          m_time++;
        end
      end
    endcase
    r = '0;
    r.kind = KIND_DONE;
    r.entry_id = rid;
    r.entry_port = rport;
    r.status = st;
    r.last = 1'b1;
    step_q.insert(step_q.size(), r);
    foreach (step_q[k]) begin
      step_q[k].member_count = 6'(m_count);
      expected_results.insert(expected_results.size(), step_q[k]);
    end
  endtask

  // result checker: no back-pressure, every strobe is a transaction
  always @(posedge clk) begin
    hbmt_out_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = expected_results.pop_front();
        if (out_item !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, out_item);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(hbmt_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_membership(it);
  endtask

  // drop start and wait until every expected result is in
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OWN_ID:   m_own_id = val;
      CFG_OWN_PORT: m_own_port = val[15:0];
      CFG_PERIOD:   begin m_period = val[7:0]; m_countdown = val[7:0]; end
      CFG_TIMEOUT:  m_timeout = val[9:0];
      CFG_INTRO:    m_joined = val[0];
      default: ;
    endcase
  endtask

  function automatic hbmt_in_t mk(logic [1:0] f, logic [31:0] id, logic [15:0] port,
                                  logic [31:0] beat, logic [31:0] stamp);
    hbmt_in_t it;
    it.func = f;
    it.member_id = id;
    it.member_port = port;
    it.member_heartbeat = beat;
    it.member_timestamp = stamp;
    return it;
  endfunction

  task automatic test_unjoined_tick;
    send_item(mk(FUNC_TICK, '1, '1, '1, '1));
    send_item(mk(FUNC_BEAT, 32'h0, 16'h0, 32'h0, 32'h0));
    send_item(mk(FUNC_TICK, 32'h0, 16'h0, 32'h0, 32'h0));
    drain();
  endtask

  task automatic test_merge_and_join;
    write_reg(CFG_OWN_ID, 32'hFFFF_FFFF);
    write_reg(CFG_OWN_PORT, 32'h0000_FFFF);
    write_reg(3'(CFG_INTRO + 1), 32'hFFFF_FFFF); // out of range index, ignored
    send_item(mk(FUNC_BEAT, 32'hFFFF_FFFF, 16'hFFFF, 32'd3, 32'h0));   // self
    send_item(mk(FUNC_BEAT, 32'd7, 16'd1, 32'd5, 32'h0));
    send_item(mk(FUNC_BEAT, 32'd7, 16'd1, 32'd5, 32'h0));               // equal beat
    send_item(mk(FUNC_BEAT, 32'd7, 16'd1, 32'd4, 32'h0));               // older beat
    send_item(mk(FUNC_BEAT, 32'd7, 16'd2, 32'hFFFF_FFFF, 32'h0));       // same id, other port
    send_item(mk(FUNC_JOIN, 32'd9, 16'd3, 32'd0, 32'h0));
    send_item(mk(FUNC_ENTRY, 32'd7, 16'd1, 32'd6, 32'hFFFF_FFFF));      // newer, stamp -1
    send_item(mk(FUNC_ENTRY, 32'd11, 16'd4, 32'd1, 32'h7FFF_FFFF));
    send_item(mk(FUNC_JOIN, 32'd9, 16'd3, 32'd1, 32'h0));
    drain();
  endtask

  task automatic test_gossip_and_removal;
    write_reg(CFG_PERIOD, 32'd0);
    write_reg(CFG_TIMEOUT, 32'd0);
    repeat (6) send_item(mk(FUNC_TICK, 32'd0, 16'd0, 32'd0, 32'd0));
    drain();
    write_reg(CFG_PERIOD, 32'd2);
    write_reg(CFG_TIMEOUT, 32'd1);
    send_item(mk(FUNC_BEAT, 32'd20, 16'd20, 32'd1, 32'd0));
    repeat (5) send_item(mk(FUNC_TICK, 32'd0, 16'd0, 32'd0, 32'd0));
    drain();
    write_reg(CFG_INTRO, 32'd0);
    send_item(mk(FUNC_TICK, 32'd0, 16'd0, 32'd0, 32'd0));
    drain();
  endtask

  task automatic test_table_full;
    write_reg(CFG_TIMEOUT, 32'd1023);
    write_reg(CFG_PERIOD, 32'd255);
    write_reg(CFG_INTRO, 32'd1);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(mk(FUNC_BEAT, 32'h100 + i, 16'(i), 32'd1, 32'd0));
    send_item(mk(FUNC_JOIN, 32'h999, 16'd9, 32'd1, 32'd0));
    send_item(mk(FUNC_ENTRY, 32'h998, 16'd9, 32'd1, 32'd0));
    send_item(mk(FUNC_TICK, 32'd0, 16'd0, 32'd0, 32'd0));
    drain();
    // age out every member but the own entry with a zero timeout, one removal per tick
    write_reg(CFG_TIMEOUT, 32'd0);
    no_gaps = 1'b1;
    repeat (DEPTH + 4) send_item(mk(FUNC_TICK, 32'd0, 16'd0, 32'd0, 32'd0));
    no_gaps = 1'b0;
    drain();
  endtask

  function automatic hbmt_in_t random_item();
    hbmt_in_t it;
    int pick;
    it.member_id = 32'h40 + $urandom_range(0, 9);
    it.member_port = 16'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) begin
      it.member_id = m_own_id;
      it.member_port = m_own_port;
    end
    it.member_heartbeat = $urandom_range(0, 40);
    pick = $urandom_range(0, 2);
    it.member_timestamp = (pick == 0) ? m_time - $urandom_range(0, 30) :
                          (pick == 1) ? 32'hFFFF_FFFF : m_time;
    pick = $urandom_range(0, 99);
    it.func = (pick < 40) ? FUNC_TICK : (pick < 65) ? FUNC_BEAT :
              (pick < 78) ? FUNC_JOIN : FUNC_ENTRY;
    if ($urandom_range(0, 11) == 0) begin
      it.member_id = $urandom;
      it.member_port = 16'($urandom);
      it.member_heartbeat = $urandom;
      it.member_timestamp = $urandom;
    end
    return it;
  endfunction

  task automatic test_random;
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_reg(CFG_OWN_ID, ($urandom_range(0, 3) == 0) ? $urandom : 32'h40 + $urandom_range(0, 9));
      write_reg(CFG_OWN_PORT, $urandom_range(0, 2));
      write_reg(CFG_PERIOD, (phase == 5) ? 32'd255 : $urandom_range(0, 6));
      write_reg(CFG_TIMEOUT, (phase == 4) ? 32'd1023 : $urandom_range(0, 40));
      write_reg(CFG_INTRO, (phase == 0) ? 32'd0 : $urandom_range(0, 1));
      no_gaps = (phase == 2);
      repeat (64) send_item(random_item());
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unjoined_tick();
    test_merge_and_join();
    test_gossip_and_removal();
    test_table_full();
    test_random();
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) failed = 1'b1;
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hbmt_pkg.sv
hdl/hbmt_front.sv
hdl/hbmt_back.sv
hdl/heartbeat_membership_table_unit.sv
dv/tb_top.sv
